// File: src/fvg_pkg.sv
// Package: shared types, constants and status codes for the FAT volume geometry unit.
`default_nettype none
package fvg_pkg;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_CORRUPT     = 2'd1;
    localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

    localparam logic [1:0] TYPE_FAT12 = 2'd0;
    localparam logic [1:0] TYPE_FAT16 = 2'd1;
    localparam logic [1:0] TYPE_FAT32 = 2'd2;

    localparam logic [31:0] FAT16_MIN   = 32'd4085;
    localparam logic [31:0] FAT32_MIN   = 32'd65525;
    localparam logic [31:0] ROOT_MASK   = 32'h0fff_ffff;
    localparam int          QUO_BITS    = 32;

    typedef struct packed {
        logic [15:0] sector_bytes;
        logic [7:0]  cluster_sectors_raw;
        logic [15:0] reserved_raw;
        logic [7:0]  table_copies;
        logic [15:0] root_entry_count;
        logic [15:0] total_short;
        logic [31:0] total_long;
        logic [15:0] table_size_short;
        logic [31:0] table_size_long;
        logic [31:0] root_cluster_raw;
    } fvg_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  volume_type;
        logic [8:0]  cluster_size;
        logic [31:0] table_start;
        logic [31:0] table_length;
        logic [31:0] root_base;
        logic [31:0] data_base;
        logic [31:0] vol_sectors;
        logic [31:0] clus_total;
        logic [27:0] root_clus;
        logic        layout_sixteen;
        logic        layout_thirtytwo;
    } fvg_out_t;

    // Layout carried from the front end to the divider and back end.
    typedef struct packed {
        logic        bad;
        logic [8:0]  csize;
        logic [31:0] reserved;
        logic [31:0] tab;
        logic [31:0] root_base;
        logic [31:0] data_base;
        logic [31:0] total;
        logic [27:0] root_clus;
        logic        l16;
        logic        l32;
        logic [1:0]  req;
    } fvg_geo_t;

endpackage
`default_nettype wire

// File: src/fvg_if.sv
// Interfaces: valid/ready channels for input and result beats.
`default_nettype none
interface fvg_in_if
    import fvg_pkg::*;
();
    logic    valid;
    logic    ready;
    fvg_in_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fvg_out_if
    import fvg_pkg::*;
();
    logic     valid;
    logic     ready;
    fvg_out_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/fvg_front.sv
// Front end: scaling, overflow checks and layout sums in three stages.
`default_nettype none
module fvg_front
    import fvg_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  wire logic     in_valid,
    input  wire fvg_in_t  in_data,
    input  wire logic [1:0] req,
    output logic          out_valid,
    output fvg_geo_t      out_geo
);

    // stage A: select and scale, 33-bit to catch overflow
    logic        a_v_reg;
    logic        a_bad_reg;
    logic [32:0] a_total_reg, a_res_reg, a_tab_reg;
    logic [7:0]  a_copies_reg;
    logic [8:0]  a_csize_reg;
    logic [12:0] a_rsec_reg;
    logic [27:0] a_rc_reg;
    logic        a_l16_reg, a_l32_reg;
    logic [1:0]  a_req_reg;

    logic        a_bad_next;
    logic [32:0] a_total_next, a_res_next, a_tab_next;
    logic [31:0] sel_total, sel_tab;
    logic        s1, s2;

    always_comb
    begin
        s1 = in_data.sector_bytes == 16'd512;
        s2 = in_data.sector_bytes == 16'd1024;
        sel_total = (in_data.total_short != 16'd0) ? {16'd0, in_data.total_short}
                                                   : in_data.total_long;
        sel_tab = (in_data.table_size_short != 16'd0) ? {16'd0, in_data.table_size_short}
                                                      : in_data.table_size_long;
        a_total_next = s2 ? {sel_total, 1'b0} : {1'b0, sel_total};
        a_tab_next   = s2 ? {sel_tab, 1'b0} : {1'b0, sel_tab};
        a_res_next   = s2 ? {16'd0, in_data.reserved_raw, 1'b0}
                          : {17'd0, in_data.reserved_raw};
        a_bad_next = !(s1 || s2) || in_data.cluster_sectors_raw == 8'd0
            || in_data.reserved_raw == 16'd0 || in_data.table_copies == 8'd0
            || sel_tab == 32'd0 || sel_total == 32'd0
            || a_total_next[32] || a_tab_next[32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else if (en)
            a_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_bad_reg    <= a_bad_next;
            a_total_reg  <= a_total_next;
            a_res_reg    <= a_res_next;
            a_tab_reg    <= a_tab_next;
            a_copies_reg <= in_data.table_copies;
            a_csize_reg  <= s2 ? {in_data.cluster_sectors_raw, 1'b0}
                               : {1'b0, in_data.cluster_sectors_raw};
            // root sectors reach 4096 for a full entry count
            a_rsec_reg   <= 13'((({6'd0, in_data.root_entry_count} << 5) + 22'd511) >> 9);
            a_rc_reg     <= in_data.root_cluster_raw[27:0];
            a_l16_reg    <= in_data.table_size_short != 16'd0
                            && in_data.root_entry_count != 16'd0;
            a_l32_reg    <= in_data.table_size_short == 16'd0
                            && in_data.table_size_long != 32'd0
                            && in_data.root_entry_count == 16'd0;
            a_req_reg    <= req;
        end
    end

    // stage B: table area = tab * copies (32x8 multiply)
    logic        b_v_reg;
    fvg_geo_t    b_geo_reg;
    logic [39:0] b_area_reg;
    logic [12:0] b_rsec_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_v_reg <= 1'b0;
        else if (en)
            b_v_reg <= a_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_area_reg <= a_tab_reg[31:0] * a_copies_reg;
            b_rsec_reg <= a_rsec_reg;
            b_geo_reg  <= '{bad: a_bad_reg, csize: a_csize_reg,
                            reserved: a_res_reg[31:0], tab: a_tab_reg[31:0],
                            root_base: 32'd0, data_base: 32'd0,
                            total: a_total_reg[31:0], root_clus: a_rc_reg,
                            l16: a_l16_reg, l32: a_l32_reg, req: a_req_reg};
        end
    end

    // stage C: root start, data start, their overflow checks and the no-data-area check
    logic [40:0] rs_wide;
    logic [41:0] ds_wide;
    fvg_geo_t    c_geo_next;

    always_comb
    begin
        rs_wide = {9'd0, b_geo_reg.reserved} + {1'b0, b_area_reg};
        ds_wide = {1'b0, rs_wide} + {29'd0, b_rsec_reg};
        c_geo_next = b_geo_reg;
        c_geo_next.root_base = rs_wide[31:0];
        c_geo_next.data_base = ds_wide[31:0];
        c_geo_next.bad = b_geo_reg.bad || (rs_wide[40:32] != 9'd0)
            || (ds_wide[41:32] != 10'd0) || (ds_wide[31:0] >= b_geo_reg.total);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= b_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_geo <= c_geo_next;
    end

endmodule
`default_nettype wire

// File: src/fvg_div.sv
// Pipelined restoring divider, one quotient bit per stage, geometry rides along.
`default_nettype none
module fvg_div
    import fvg_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  wire logic     in_valid,
    input  wire fvg_geo_t in_geo,
    output logic          out_valid,
    output fvg_geo_t      out_geo,
    output logic [31:0]   out_quo
);

    logic        v_reg   [QUO_BITS+1];
    fvg_geo_t    geo_reg [QUO_BITS+1];
    logic [31:0] num_reg [QUO_BITS+1];
    logic [31:0] rem_reg [QUO_BITS+1];

    // entry: dividend is the data area
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            geo_reg[0] <= in_geo;
            num_reg[0] <= in_geo.total - in_geo.data_base;
            rem_reg[0] <= 32'd0;
        end
    end

    for (genvar i = 0; i < QUO_BITS; i++)
    begin : g_stage
        logic [32:0] trial;
        logic [32:0] den;
        always_comb
        begin
            den   = {24'd0, geo_reg[i].csize};
            trial = {rem_reg[i], num_reg[i][31]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i+1] <= 1'b0;
            else if (en)
                v_reg[i+1] <= v_reg[i];
        end

        // shift one dividend bit in; quotient bits fill from the bottom
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                geo_reg[i+1] <= geo_reg[i];
                if (trial >= den)
                begin
                    rem_reg[i+1] <= 32'(trial - den);
                    num_reg[i+1] <= {num_reg[i][30:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1] <= trial[31:0];
                    num_reg[i+1] <= {num_reg[i][30:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = v_reg[QUO_BITS];
    assign out_geo   = geo_reg[QUO_BITS];
    assign out_quo   = num_reg[QUO_BITS];

endmodule
`default_nettype wire

// File: src/fvg_back.sv
// Back end: type class, FAT32 checks, required type match, result register.
`default_nettype none
module fvg_back
    import fvg_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  wire logic     in_valid,
    input  wire fvg_geo_t in_geo,
    input  wire logic [31:0] in_count,
    output logic          out_valid,
    output fvg_out_t      out_data
);

    logic [1:0]  typ;
    logic        corrupt, unsup;
    fvg_out_t    res;

    always_comb
    begin
        typ = (in_count < FAT16_MIN) ? TYPE_FAT12
            : (in_count < FAT32_MIN) ? TYPE_FAT16 : TYPE_FAT32;
        corrupt = in_geo.bad || (typ == TYPE_FAT32 && (!in_geo.l32
            || in_geo.root_clus < 28'd2
            || {5'd0, in_geo.root_clus} >= {1'b0, in_count} + 33'd2));
        unsup = typ != in_geo.req || (in_geo.req == TYPE_FAT16 && !in_geo.l16)
            || (in_geo.req == TYPE_FAT32 && !in_geo.l32);
        res = '0;
        if (corrupt)
            res.status = ST_CORRUPT;
        else if (unsup)
            res.status = ST_UNSUPPORTED;
        else
        begin
            res.status           = ST_OK;
            res.volume_type      = typ;
            res.cluster_size     = in_geo.csize;
            res.table_start      = in_geo.reserved;
            res.table_length     = in_geo.tab;
            res.root_base        = in_geo.root_base;
            res.data_base        = in_geo.data_base;
            res.vol_sectors      = in_geo.total;
            res.clus_total       = in_count;
            res.root_clus        = in_geo.root_clus;
            res.layout_sixteen   = in_geo.l16;
            res.layout_thirtytwo = in_geo.l32;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data <= res;
    end

`ifndef ASSERT_OFF
    a_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.vol_sectors == 32'd0
            && out_data.cluster_size == 9'd0)
        else $error("non-ok result carries layout");
    a_ok_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_OK |-> out_data.data_base
            < out_data.vol_sectors)
        else $error("ok result without data area");
    a_fat32_root: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_OK && out_data.volume_type == TYPE_FAT32
            |-> out_data.root_clus >= 28'd2 && out_data.layout_thirtytwo)
        else $error("bad FAT32 root accepted");
`endif

endmodule
`default_nettype wire

// File: src/fat_volume_geometry_unit.sv
// Top level: FAT boot-sector geometry and type check, fully pipelined.
// Usage:
//   in  : one beat carries the raw boot-sector fields of one volume.
//   out : one beat per input with status, type and layout in 512-byte units.
//   The user writes the demanded FAT type by cfg_we/cfg_data only while the
//   block is idle, not enforced by the block. Throughput: one beat per
//   cycle unless out stalls. Stages: three front, one divider entry, 32 in
//   the divider of one quotient bit each, one result stage.
// The pipeline advances as a whole: when the result register holds an
//   untaken beat, all stages hold; in.ready is out.ready or an empty result
//   register, so a stall loses and repeats nothing.
// Reset clears every valid bit and sets the demanded type to FAT12.
// Every field other than status is zero unless status is ok.
`default_nettype none
module fat_volume_geometry_unit
    import fvg_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    fvg_in_if.sink           in,
    fvg_out_if.source        out,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_data
);

    logic       en;
    logic [1:0] req_reg;
    logic       f_v, d_v;
    fvg_geo_t   f_geo, d_geo;
    logic [31:0] d_quo;

    assign en       = out.ready || !out.valid;
    assign in.ready = en;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_reg <= TYPE_FAT12;
        else if (cfg_we)
            req_reg <= cfg_data;
    end

    fvg_front u_front (.clk, .rst_n, .en, .in_valid(in.valid), .in_data(in.data),
        .req(req_reg), .out_valid(f_v), .out_geo(f_geo));

    fvg_div u_div (.clk, .rst_n, .en, .in_valid(f_v), .in_geo(f_geo),
        .out_valid(d_v), .out_geo(d_geo), .out_quo(d_quo));

    fvg_back u_back (.clk, .rst_n, .en, .in_valid(d_v), .in_geo(d_geo),
        .in_count(d_quo), .out_valid(out.valid), .out_data(out.data));

endmodule
`default_nettype wire

// File: tb/tb.sv
// Testbench for the FAT volume geometry unit: predicted results checked per beat.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import fvg_pkg::*;

    localparam longint unsigned MAX32 = 64'hffff_ffff;
    localparam int DRAIN_CYCLES = 45;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_data = '0;

    fvg_in_if in_bus ();
    fvg_out_if out_bus ();

    fat_volume_geometry_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in       (in_bus),
        .out      (out_bus),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    fvg_out_t expected_geometry[$];
    logic [1:0] cfg_type = TYPE_FAT12;
    int mismatch_count = 0;
    int burst_left = 0;
    int cycle_count = 0;

    always #1 clk = ~clk;

    initial
    begin
        in_bus.valid = 1'b0;
        in_bus.data = '0;
        out_bus.ready = 1'b0;
    end

    // Golden geometry computation, wide arithmetic catches every 32-bit overflow.
    function automatic fvg_out_t predict_geometry(fvg_in_t v, logic [1:0] req);
        longint unsigned scale, total, tab, res, phys, rs, rstart, meta, csize, count, rc;
        logic l16, l32;
        logic [1:0] vt;
        fvg_out_t r;
        r = '0;
        r.status = ST_CORRUPT;
        scale = (v.sector_bytes == 16'd512) ? 1 : (v.sector_bytes == 16'd1024) ? 2 : 0;
        total = (v.total_short != 0) ? v.total_short : v.total_long;
        tab = (v.table_size_short != 0) ? v.table_size_short : v.table_size_long;
        if (scale == 0 || v.cluster_sectors_raw == 0 || v.reserved_raw == 0 ||
            v.table_copies == 0 || tab == 0 || total == 0)
            return r;
        phys = total * scale;
        res = v.reserved_raw * scale;
        tab = tab * scale;
        if (phys > MAX32 || tab > MAX32)
            return r;
        rstart = res + tab * v.table_copies;
        if (rstart > MAX32)
            return r;
        rs = (longint'(v.root_entry_count) * 32 + 511) >> 9;
        meta = rstart + rs;
        if (meta > MAX32 || meta >= phys)
            return r;
        csize = v.cluster_sectors_raw * scale;
        count = (phys - meta) / csize;
        vt = (count < 4085) ? TYPE_FAT12 : (count < 65525) ? TYPE_FAT16 : TYPE_FAT32;
        l16 = v.table_size_short != 0 && v.root_entry_count != 0;
        l32 = v.table_size_short == 0 && v.table_size_long != 0 && v.root_entry_count == 0;
        rc = v.root_cluster_raw & ROOT_MASK;
        if (vt == TYPE_FAT32 && (!l32 || rc < 2 || rc >= count + 2))
            return r;
        if (vt != req || (req == TYPE_FAT16 && !l16) || (req == TYPE_FAT32 && !l32))
        begin
            r.status = ST_UNSUPPORTED;
            return r;
        end
        r.status = ST_OK;
        r.volume_type = vt;
        r.cluster_size = csize[8:0];
        r.table_start = res[31:0];
        r.table_length = tab[31:0];
        r.root_base = rstart[31:0];
        r.data_base = meta[31:0];
        r.vol_sectors = phys[31:0];
        r.clus_total = count[31:0];
        r.root_clus = rc[27:0];
        r.layout_sixteen = l16;
        r.layout_thirtytwo = l32;
        return r;
    endfunction

    // Fully random fields.
    function automatic fvg_in_t noise_volume();
        fvg_in_t v;
        v.sector_bytes = 16'($urandom);
        v.cluster_sectors_raw = 8'($urandom);
        v.reserved_raw = 16'($urandom);
        v.table_copies = 8'($urandom);
        v.root_entry_count = 16'($urandom);
        v.total_short = 16'($urandom);
        v.total_long = $urandom;
        v.table_size_short = 16'($urandom);
        v.table_size_long = $urandom;
        v.root_cluster_raw = $urandom;
        return v;
    endfunction

    // Well-formed volume aimed at one FAT type, random content.
    function automatic fvg_in_t make_volume(logic [1:0] kind);
        fvg_in_t v;
        longint unsigned scale, spc, csize, res, copies, tab, ents, meta, count, need, total;
        v = noise_volume();
        scale = $urandom_range(1, 2);
        v.sector_bytes = (scale == 1) ? 16'd512 : 16'd1024;
        if (kind != TYPE_FAT32 && $urandom_range(0, 3) == 0)
            spc = $urandom_range(1, 255);
        else
            spc = 1 << $urandom_range(0, 7);
        csize = spc * scale;
        res = (kind == TYPE_FAT32) ? 32 : $urandom_range(1, 64);
        copies = $urandom_range(1, 3);
        tab = (kind == TYPE_FAT32) ? $urandom_range(1, 20000) : $urandom_range(1, 300);
        ents = (kind == TYPE_FAT32) ? 0 : $urandom_range(1, 1024);
        case (kind)
            TYPE_FAT12: count = $urandom_range(0, 7) == 0 ? 4084 : $urandom_range(1, 4084);
            TYPE_FAT16: count = $urandom_range(0, 7) == 0 ? 4085 : $urandom_range(4085, 65524);
            default:    count = $urandom_range(0, 7) == 0 ? 65525 : $urandom_range(65525, 4000000);
        endcase
        meta = (res + tab * copies) * scale + ((ents * 32 + 511) >> 9);
        need = meta + count * csize + $urandom_range(0, csize - 1);
        total = (need + scale - 1) / scale;
        v.cluster_sectors_raw = spc[7:0];
        v.reserved_raw = res[15:0];
        v.table_copies = copies[7:0];
        v.root_entry_count = ents[15:0];
        if (kind == TYPE_FAT32)
        begin
            v.table_size_short = '0;
            v.table_size_long = tab[31:0];
            v.root_cluster_raw[27:0] = 28'($urandom_range(2, count + 1));
        end
        else
            v.table_size_short = tab[15:0];
        if (total < 65536 && $urandom_range(0, 1) == 1)
            v.total_short = total[15:0];
        else
        begin
            v.total_short = '0;
            v.total_long = total[31:0];
        end
        return v;
    endfunction

    // Well-formed volume with one field replaced by noise.
    function automatic fvg_in_t broken_volume(logic [1:0] kind);
        fvg_in_t v, n;
        v = make_volume(kind);
        n = noise_volume();
        case ($urandom_range(0, 9))
            0: v.sector_bytes = n.sector_bytes;
            1: v.cluster_sectors_raw = n.cluster_sectors_raw;
            2: v.reserved_raw = n.reserved_raw;
            3: v.table_copies = n.table_copies;
            4: v.root_entry_count = n.root_entry_count;
            5: v.total_short = n.total_short;
            6: v.total_long = n.total_long;
            7: v.table_size_short = n.table_size_short;
            8: v.table_size_long = n.table_size_long;
            default: v.root_cluster_raw = n.root_cluster_raw;
        endcase
        return v;
    endfunction

    // Present one beat and hold until accepted.
    task automatic send_volume(input fvg_in_t v);
        @(negedge clk);
        in_bus.valid <= 1'b1;
        in_bus.data <= v;
        do
            @(posedge clk);
        while (!in_bus.ready);
        expected_geometry.push_back(predict_geometry(v, cfg_type));
    endtask

    // Burst pacing: random gaps between bursts of random length.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        gap = $urandom_range(1, 6);
        @(negedge clk);
        in_bus.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
        burst_left = $urandom_range(0, 40);
    endtask

    task automatic wait_results();
        while (expected_geometry.size() != 0)
            @(posedge clk);
    endtask

    // Register write only with the pipeline empty.
    task automatic set_required_type(input logic [1:0] t);
        @(negedge clk);
        in_bus.valid <= 1'b0;
        wait_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= t;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_type = t;
    endtask

    // Receiver stall pattern: open, random, sparse, open, in turn as cycle_count advances.
    always @(negedge clk)
    begin
        cycle_count <= cycle_count + 1;
        case ((cycle_count / 64) % 4)
            0, 3: out_bus.ready <= 1'b1;
            1: out_bus.ready <= $urandom_range(0, 1);
            default: out_bus.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // Result checker.
    always @(posedge clk)
    begin
        fvg_out_t got, want;
        if (rst_n && out_bus.valid && out_bus.ready)
        begin
            got = out_bus.data;
            if (expected_geometry.size() == 0)
                report_mismatch("unexpected beat", got.status, 0);
            else
            begin
                want = expected_geometry.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
                if (got.volume_type != want.volume_type)
                    report_mismatch("volume_type", got.volume_type, want.volume_type);
                if (got.cluster_size != want.cluster_size)
                    report_mismatch("cluster_size", got.cluster_size, want.cluster_size);
                if (got.table_start != want.table_start)
                    report_mismatch("table_start", got.table_start, want.table_start);
                if (got.table_length != want.table_length)
                    report_mismatch("table_length", got.table_length, want.table_length);
                if (got.root_base != want.root_base)
                    report_mismatch("root_base", got.root_base, want.root_base);
                if (got.data_base != want.data_base)
                    report_mismatch("data_base", got.data_base, want.data_base);
                if (got.vol_sectors != want.vol_sectors)
                    report_mismatch("vol_sectors", got.vol_sectors, want.vol_sectors);
                if (got.clus_total != want.clus_total)
                    report_mismatch("clus_total", got.clus_total, want.clus_total);
                if (got.root_clus != want.root_clus)
                    report_mismatch("root_clus", got.root_clus, want.root_clus);
                if (got.layout_sixteen != want.layout_sixteen)
                    report_mismatch("layout_sixteen", got.layout_sixteen, want.layout_sixteen);
                if (got.layout_thirtytwo != want.layout_thirtytwo)
                    report_mismatch("layout_thirtytwo", got.layout_thirtytwo,
                                    want.layout_thirtytwo);
            end
        end
    end

    // Corner cases: bad sizes, zero fields, overflow, no data area, FAT32 checks, type mismatch.
    task automatic test_corner_cases();
        fvg_in_t v;
        v = make_volume(TYPE_FAT12);
        send_volume(v);
        v.sector_bytes = 16'd0;      send_volume(v);
        v.sector_bytes = 16'hffff;   send_volume(v);
        v.sector_bytes = 16'd513;    send_volume(v);
        v = make_volume(TYPE_FAT12); v.cluster_sectors_raw = 0; send_volume(v);
        v = make_volume(TYPE_FAT12); v.reserved_raw = 0; send_volume(v);
        v = make_volume(TYPE_FAT12); v.table_copies = 0; send_volume(v);
        v = make_volume(TYPE_FAT12); v.table_size_short = 0; v.table_size_long = 0;
        send_volume(v);
        v = make_volume(TYPE_FAT12); v.total_short = 0; v.total_long = 0; send_volume(v);
        // total overflows when doubled
        v = make_volume(TYPE_FAT32); v.sector_bytes = 16'd1024; v.total_long = '1;
        send_volume(v);
        // table overflows when doubled, and table times copies overflows
        v = make_volume(TYPE_FAT32); v.sector_bytes = 16'd1024; v.table_size_long = '1;
        send_volume(v);
        v = make_volume(TYPE_FAT32); v.table_size_long = 32'h8000_0000; v.table_copies = 2;
        v.total_long = '1; send_volume(v);
        // root area pushes the sum past 32 bits
        v = make_volume(TYPE_FAT16); v.sector_bytes = 16'd512; v.reserved_raw = 16'hffff;
        v.table_size_short = 0; v.table_size_long = 32'hfffe_ffff; v.table_copies = 1;
        v.root_entry_count = 16'hffff; v.total_short = 0; v.total_long = '1;
        send_volume(v);
        // full root entry count on an otherwise sound volume
        v = make_volume(TYPE_FAT12); v.root_entry_count = 16'hffff; v.total_short = 0;
        v.total_long = 32'd100000; send_volume(v);
        // metadata fills the volume
        v = make_volume(TYPE_FAT12); v.total_short = 1; send_volume(v);
        // FAT32 without its layout, root cluster out of range
        v = make_volume(TYPE_FAT32); v.root_entry_count = 16; send_volume(v);
        v = make_volume(TYPE_FAT32); v.root_cluster_raw = 32'hf000_0001; send_volume(v);
        v = make_volume(TYPE_FAT32); v.root_cluster_raw = 32'h0fff_ffff; send_volume(v);
        v = make_volume(TYPE_FAT32); v.root_cluster_raw = 32'h0000_0000; send_volume(v);
        // type mismatch
        send_volume(make_volume(TYPE_FAT16));
        send_volume(make_volume(TYPE_FAT32));
        v = '1; send_volume(v);
        v = '0; send_volume(v);
    endtask

    // One phase per register setting, mostly matching volumes (random kinds for setting 3).
    task automatic test_type_phase(input logic [1:0] t, input int items);
        logic [1:0] kind;
        int pick;
        set_required_type(t);
        for (int i = 0; i < items; i++)
        begin
            pick = $urandom_range(0, 99);
            kind = (pick < 50 && t != 2'd3) ? t : 2'($urandom_range(0, 2));
            if (pick < 75)
                send_volume(make_volume(kind));
            else if (pick < 90)
                send_volume(broken_volume(kind));
            else
                send_volume(noise_volume());
            pace_sender();
        end
    endtask

    // Flags that disagree with the required FAT16 layout.
    task automatic test_layout_flags();
        fvg_in_t v;
        set_required_type(TYPE_FAT16);
        v = make_volume(TYPE_FAT16);
        v.root_entry_count = 0;
        send_volume(v);
        send_volume(make_volume(TYPE_FAT16));
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_corner_cases();
        test_layout_flags();
        test_type_phase(TYPE_FAT16, 90);
        test_type_phase(TYPE_FAT32, 90);
        test_type_phase(2'd3, 50);
        test_type_phase(TYPE_FAT12, 90);
        test_type_phase(TYPE_FAT32, 60);
        test_type_phase(TYPE_FAT16, 50);
        @(negedge clk);
        in_bus.valid <= 1'b0;
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_geometry.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #500000;
        $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
src/fvg_pkg.sv
src/fvg_if.sv
src/fvg_front.sv
src/fvg_div.sv
src/fvg_back.sv
src/fat_volume_geometry_unit.sv
tb/tb.sv
